// File: rtl/core/lse_pkg.sv
// shared types, constants and helpers for the legendre series evaluator
package lse_pkg;

   // term limit of the recurrence and default term capacity
   localparam int unsigned LSE_TERMS_LIMIT = 7;
   localparam int unsigned LSE_MAX_TERMS   = 7;

   // field widths
   localparam int unsigned X_W    = 16;  // sample, q1.15
   localparam int unsigned P_W    = 32;  // legendre value, q2.30
   localparam int unsigned COEF_W = 16;  // weight, q2.14
   localparam int unsigned SUM_W  = 32;  // result, q19.13
   localparam int unsigned CNT_W  = 3;   // term count
   localparam int unsigned IDX_W  = 3;   // csr register index
   localparam int unsigned ACC_W  = 56;  // series accumulator, q44

   // csr register indexes
   localparam logic [IDX_W-1:0] REG_TERM_COUNT = 3'd0;
   localparam logic [IDX_W-1:0] REG_COEF_0     = 3'd1;

   // fixed values
   localparam logic signed [P_W-1:0]   P0_ONE    = 32'sh4000_0000;  // 1.0 in q2.30
   localparam logic signed [SUM_W-1:0] SUM_ONE   = 32'sd8192;       // 1.0 in q13

   // item travelling down the pipeline
   typedef struct packed {
      logic [CNT_W-1:0]                  term_num;
      logic signed [X_W-1:0]             x;
      logic [LSE_TERMS_LIMIT-1:0][P_W-1:0] p;
   } lse_item_type;

   // reciprocal of k+1 scaled by 2^24, rounded
   function automatic logic [23:0] lse_recip(input int unsigned k1);
      logic [23:0] r;
      case (k1)
         2:       r = 24'd8388608;
         3:       r = 24'd5592405;
         4:       r = 24'd4194304;
         5:       r = 24'd3355443;
         6:       r = 24'd2796203;
         default: r = 24'd0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/core/lse_if.sv
// stream and csr interfaces of the legendre series evaluator
interface lse_req_if;
   logic              valid;
   logic              ready;
   logic signed [15:0] sample_x;
   modport source (output valid, output sample_x, input ready);
   modport sink   (input valid, input sample_x, output ready);
endinterface

interface lse_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] series_sum;
   modport source (output valid, output series_sum, input ready);
   modport sink   (input valid, input series_sum, output ready);
endinterface

interface lse_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  reg_index;
   logic [15:0] wr_data;
   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// File: rtl/core/lse_step.sv
// one bonnet recurrence step in three pipeline stages: p[k] -> p[k+1]
module lse_step
   import lse_pkg::*;
#(
   parameter int unsigned K = 1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  lse_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output lse_item_type out_item
);

   localparam logic signed [19:0] ODD_F = 20'(2 * K + 1);
   localparam logic signed [37:0] K_F   = 38'(K);
   localparam logic signed [62:0] R_F   = 63'(lse_recip(K + 1));

   logic a_load, b_load, c_load;

   logic               a_valid_ff, a_valid_in;
   lse_item_type       a_item_ff, a_item_in;
   logic signed [51:0] a_prod_ff, a_prod_in;

   logic               b_valid_ff, b_valid_in;
   lse_item_type       b_item_ff, b_item_in;
   logic signed [37:0] b_num_ff, b_num_in;

   logic               c_valid_ff, c_valid_in;
   lse_item_type       c_item_ff, c_item_in;
   logic signed [62:0] c_prod_ff, c_prod_in;

   logic signed [19:0] odd_x;
   logic signed [51:0] a_rnd;
   logic signed [36:0] a_q;
   logic signed [62:0] c_rnd;

   // ready chain, back from the output
   always_comb begin
      c_load   = !c_valid_ff || out_ready;
      b_load   = !b_valid_ff || c_load;
      a_load   = !a_valid_ff || b_load;
      in_ready = a_load;
   end

   // stage a: (2k+1) * x * p[k]
   always_comb begin
      odd_x      = ODD_F * 20'(in_item.x);
      a_prod_in  = 52'(odd_x) * 52'($signed(in_item.p[K]));
      a_item_in  = in_item;
      a_valid_in = a_load ? in_valid : a_valid_ff;
   end

   // stage b: round off 15 bits, subtract k * p[k-1]
   always_comb begin
      a_rnd      = a_prod_ff + 52'sd16384;
      a_q        = 37'(a_rnd >>> 15);
      b_num_in   = 38'(a_q) - K_F * 38'($signed(a_item_ff.p[K-1]));
      b_item_in  = a_item_ff;
      b_valid_in = b_load ? a_valid_ff : b_valid_ff;
   end

   // stage c: times reciprocal of k+1
   always_comb begin
      c_prod_in  = 63'(b_num_ff) * R_F;
      c_item_in  = b_item_ff;
      c_valid_in = c_load ? b_valid_ff : c_valid_ff;
   end

   // round off 24 bits into p[k+1]
   always_comb begin
      c_rnd        = c_prod_ff + 63'sd8388608;
      out_item     = c_item_ff;
      out_item.p[K+1] = P_W'(c_rnd >>> 24);
      out_valid    = c_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_item_ff <= a_item_in;
         a_prod_ff <= a_prod_in;
      end
      if (b_load) begin
         b_item_ff <= b_item_in;
         b_num_ff  <= b_num_in;
      end
      if (c_load) begin
         c_item_ff <= c_item_in;
         c_prod_ff <= c_prod_in;
      end
   end

endmodule

// File: rtl/core/lse_sum.sv
// weighted series sum: products, odd weights, adder tree, final rounding
module lse_sum
   import lse_pkg::*;
#(
   parameter int unsigned MAX_TERMS = LSE_MAX_TERMS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  lse_item_type                           in_item,
   input  logic [LSE_TERMS_LIMIT-1:0][COEF_W-1:0] coef,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic signed [SUM_W-1:0]                out_sum
);

   localparam int unsigned NSTG = 5;

   logic [NSTG-1:0] v_ff, v_in, load;

   logic [LSE_TERMS_LIMIT-1:0][47:0]    s1_prod_ff, s1_prod_in;
   logic [NSTG-2:0]                     zero_ff, zero_in;
   logic [LSE_TERMS_LIMIT:0][ACC_W-1:0] s2_w_ff, s2_w_in;
   logic [3:0][ACC_W-1:0]               s3_ff, s3_in;
   logic [1:0][ACC_W-1:0]               s4_ff, s4_in;
   logic signed [SUM_W-1:0]             s5_ff, s5_in;
   logic signed [ACC_W-1:0]             total;

   // ready chain
   always_comb begin
      load[NSTG-1] = !v_ff[NSTG-1] || out_ready;
      for (int i = NSTG - 2; i >= 0; i--) begin
         load[i] = !v_ff[i] || load[i+1];
      end
      in_ready = load[0];
      v_in[0]  = load[0] ? in_valid : v_ff[0];
      for (int i = 1; i < NSTG; i++) begin
         v_in[i] = load[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   // stage 1: p[k] * coef[k] for the terms in use
   always_comb begin
      for (int k = 0; k < LSE_TERMS_LIMIT; k++) begin
         if (k < MAX_TERMS && 3'(k) < in_item.term_num) begin
            s1_prod_in[k] = 48'($signed(in_item.p[k])) * 48'($signed(coef[k]));
         end else begin
            s1_prod_in[k] = '0;
         end
      end
      zero_in[0] = (in_item.term_num == '0);
      for (int i = 1; i < NSTG - 1; i++) begin
         zero_in[i] = zero_ff[i-1];
      end
   end

   // stage 2: times 2k+1, stage 3 and 4: adder tree
   always_comb begin
      for (int k = 0; k < LSE_TERMS_LIMIT; k++) begin
         s2_w_in[k] = ACC_W'($signed(s1_prod_ff[k])) * ACC_W'(2 * k + 1);
      end
      s2_w_in[LSE_TERMS_LIMIT] = '0;
      for (int j = 0; j < 4; j++) begin
         s3_in[j] = s2_w_ff[2*j] + s2_w_ff[2*j+1];
      end
      s4_in[0] = s3_ff[0] + s3_ff[1];
      s4_in[1] = s3_ff[2] + s3_ff[3];
   end

   // stage 5: round off 31 bits, empty series reads as one
   always_comb begin
      total = $signed(s4_ff[0] + s4_ff[1]) + ACC_W'(64'sd1073741824);
      if (zero_ff[NSTG-2]) begin
         s5_in = SUM_ONE;
      end else begin
         s5_in = SUM_W'(total >>> 31);
      end
   end

   assign out_valid = v_ff[NSTG-1];
   assign out_sum   = s5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         s1_prod_ff <= s1_prod_in;
         zero_ff[0] <= zero_in[0];
      end
      for (int i = 1; i < NSTG - 1; i++) begin
         if (load[i]) begin
            zero_ff[i] <= zero_in[i];
         end
      end
      if (load[1]) begin
         s2_w_ff <= s2_w_in;
      end
      if (load[2]) begin
         s3_ff <= s3_in;
      end
      if (load[3]) begin
         s4_ff <= s4_in;
      end
      if (load[4]) begin
         s5_ff <= s5_in;
      end
   end

endmodule

// File: rtl/core/legendre_series_evaluator.sv
// top level: csr registers, bonnet recurrence pipeline and series sum
// path: each req beat passes the step slices in order, then the sum stages, to its rsp beat
// throughput: one sample per cycle while rsp is not stalled, each recurrence step is its own three-stage slice
// a stall on rsp backs up stage by stage; empty stages still take new beats
// reset (synchronous, active high) empties the pipeline and clears all csr registers
module legendre_series_evaluator
   import lse_pkg::*;
#(
   parameter int unsigned MAX_TERMS = LSE_MAX_TERMS
) (
   input logic   clock,
   input logic   reset,
   lse_req_if.sink req_bus,
   lse_rsp_if.source rsp_bus,
   lse_csr_if.sink csr_bus
);

   // number of recurrence steps: p[2] .. p[MAX_TERMS-1]
   localparam int unsigned NSTEP = (MAX_TERMS > 2) ? MAX_TERMS - 2 : 0;

   // csr registers
   logic [CNT_W-1:0]                   term_count_ff, term_count_in;
   logic [LSE_TERMS_LIMIT-1:0][COEF_W-1:0] coef_ff, coef_in;
   logic [CNT_W-1:0]                   term_num;
   logic [IDX_W-1:0]                   coef_idx;

   // pipeline chain between the step slices
   logic         chain_valid [NSTEP+1];
   logic         chain_ready [NSTEP+1];
   lse_item_type chain_item  [NSTEP+1];

   // csr port always ready; writes are registered
   assign csr_bus.ready = 1'b1;
   assign coef_idx      = csr_bus.reg_index - REG_COEF_0;

   always_comb begin
      term_count_in = term_count_ff;
      coef_in       = coef_ff;
      if (csr_bus.valid) begin
         case (csr_bus.reg_index)
            REG_TERM_COUNT: term_count_in = csr_bus.wr_data[CNT_W-1:0];
            default:        coef_in[coef_idx] = csr_bus.wr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_count_ff <= '0;
         coef_ff       <= '0;
      end else begin
         term_count_ff <= term_count_in;
         coef_ff       <= coef_in;
      end
   end

   // term count saturates at the built capacity
   assign term_num = (term_count_ff > CNT_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS) : term_count_ff;

   // seed the item: p[0] = 1.0, p[1] = x, both exact
   always_comb begin
      chain_item[0]          = '0;
      chain_item[0].term_num = term_num;
      chain_item[0].x        = req_bus.sample_x;
      chain_item[0].p[0]     = P0_ONE;
      chain_item[0].p[1]     = P_W'(req_bus.sample_x) <<< 15;
   end

   assign chain_valid[0] = req_bus.valid;
   assign req_bus.ready  = chain_ready[0];

   // one slice per recurrence step
   for (genvar g = 1; g <= NSTEP; g++) begin : g_step
      lse_step #(
         .K (g)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g-1]),
         .in_ready  (chain_ready[g-1]),
         .in_item   (chain_item[g-1]),
         .out_valid (chain_valid[g]),
         .out_ready (chain_ready[g]),
         .out_item  (chain_item[g])
      );
   end

   // weighted sum and final rounding, output register at its end
   lse_sum #(
      .MAX_TERMS (MAX_TERMS)
   ) u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[NSTEP]),
      .in_ready  (chain_ready[NSTEP]),
      .in_item   (chain_item[NSTEP]),
      .coef      (coef_ff),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_sum   (rsp_bus.series_sum)
   );

endmodule
